/* hw/rtl/spq_pkg.sv */
// Shared types and codes for the stable priority queue.
// No dependencies; the files that use this package refer to it by scoped names.
package spq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_code_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctrl_t;

endpackage

/* hw/rtl/spq_in_if.sv */
// Request channel of the stable priority queue: valid/ready plus the request payload.
// Uses no package items.
interface spq_in_if #(
	parameter int DATA_WIDTH     = 32,
	parameter int PRIORITY_WIDTH = 16
);
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [DATA_WIDTH-1:0]     item_data;
	logic [PRIORITY_WIDTH-1:0] item_priority;

	modport source (output valid, output opcode, output item_data, output item_priority,
		input ready);
	modport sink (input valid, input opcode, input item_data, input item_priority,
		output ready);
endinterface

/* hw/rtl/spq_out_if.sv */
// Result channel of the stable priority queue: valid/ready plus the result payload.
// Uses no package items.
interface spq_out_if #(
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 5
);
	logic                    valid;
	logic                    ready;
	logic [DATA_WIDTH-1:0]   popped_data;
	logic                    popped_valid;
	logic [1:0]              error_code;
	logic [COUNT_WIDTH-1:0]  entry_count;
	logic                    queue_empty;

	modport source (output valid, output popped_data, output popped_valid,
		output error_code, output entry_count, output queue_empty, input ready);
	modport sink (input valid, input popped_data, input popped_valid,
		input error_code, input entry_count, input queue_empty, output ready);
endinterface

/* hw/rtl/stable_priority_queue_core.sv */
// Stable priority queue: a bounded store of DEPTH entries ordered by priority.
// Requests arrive on in_ch (valid/ready); each request yields one result on out_ch.
// An insert places its entry behind every stored entry of equal or higher priority;
// a pop removes the head. A full insert or an empty pop is refused with an error code.
// Entries live in a ring buffer; a pop only advances the head pointer.
// Timing: in_ch.ready is high only while the sequencer is idle, one request at a time.
// A refused request goes straight to S_FIN; a pop passes S_READ and S_STEP first.
// An insert that moves k entries toward the tail passes S_READ and S_STEP once per
// move, since each move is one memory read followed by one compare and write on the
// single port pair; it ends with one more read and compare, or a direct write at the head.
// The next request can be accepted from the cycle its predecessor's result is loaded.
// Results sit in an output register; while out_ch.ready is low the result holds and
// a finished request waits in the sequencer before it can be written out.
// Reset (arst_n low) empties the queue at once; no clearing pass is needed because
// only slots below the entry count are ever read.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_store and spq_seq.
module stable_priority_queue_core #(
	parameter int DEPTH          = 16,
	parameter int DATA_WIDTH     = 32,
	parameter int PRIORITY_WIDTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	spq_in_if.sink    in_ch,
	spq_out_if.source out_ch
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	spq_pkg::mem_ctrl_t        mem_ctl;
	logic [AW-1:0]             wr_addr;
	logic [DATA_WIDTH-1:0]     wr_data;
	logic [PRIORITY_WIDTH-1:0] wr_prio;
	logic [AW-1:0]             rd_addr;
	logic [DATA_WIDTH-1:0]     rd_data;
	logic [PRIORITY_WIDTH-1:0] rd_prio;

	spq_seq #(
		.DEPTH          (DEPTH),
		.DATA_WIDTH     (DATA_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.mem_ctl (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.wr_prio (wr_prio),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_prio (rd_prio)
	);

	spq_store #(
		.DEPTH          (DEPTH),
		.DATA_WIDTH     (DATA_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_store (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.wr_prio (wr_prio),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_prio (rd_prio)
	);

`ifndef SYNTH
	// Only one request is in flight; the next cycle after acceptance is busy.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("request accepted while another is in flight");

	// A returned entry never carries an error.
	a_pop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.popped_valid |-> out_ch.error_code == spq_pkg::ERR_NONE)
		else $error("popped entry reported with an error");

	// A refused insert happens only at full count.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error_code == spq_pkg::ERR_FULL
		|-> out_ch.entry_count == CW'(DEPTH))
		else $error("full error with entry count below depth");

	// A refused pop leaves an empty queue and returns nothing.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error_code == spq_pkg::ERR_EMPTY
		|-> out_ch.entry_count == '0 && !out_ch.popped_valid && out_ch.popped_data == '0)
		else $error("empty error with entries or data present");
`endif

endmodule

/* hw/rtl/spq_store.sv */
// Entry memory of the stable priority queue: one write port, one registered read port.
// Depends on spq_pkg for the memory control struct.
module spq_store #(
	parameter int DEPTH          = 16,
	parameter int DATA_WIDTH     = 32,
	parameter int PRIORITY_WIDTH = 16,
	localparam int AW            = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  spq_pkg::mem_ctrl_t        mem_ctl,
	input  logic [AW-1:0]             wr_addr,
	input  logic [DATA_WIDTH-1:0]     wr_data,
	input  logic [PRIORITY_WIDTH-1:0] wr_prio,
	input  logic [AW-1:0]             rd_addr,
	output logic [DATA_WIDTH-1:0]     rd_data,
	output logic [PRIORITY_WIDTH-1:0] rd_prio
);

	logic [DATA_WIDTH-1:0]     data_mem [DEPTH];
	logic [PRIORITY_WIDTH-1:0] prio_mem [DEPTH];
	logic [DATA_WIDTH-1:0]     rd_data_q;
	logic [PRIORITY_WIDTH-1:0] rd_prio_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			data_mem[wr_addr] <= wr_data;
			prio_mem[wr_addr] <= wr_prio;
		end
		if (mem_ctl.rd_en) begin
			rd_data_q <= data_mem[rd_addr];
			rd_prio_q <= prio_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign rd_prio = rd_prio_q;

endmodule

/* hw/rtl/spq_seq.sv */
// Sequencer of the stable priority queue: walks the sorted ring one entry per step,
// comparing and shifting through the memory's write and read ports. Depends on spq_pkg and both
// channel interfaces.
module spq_seq #(
	parameter int DEPTH          = 16,
	parameter int DATA_WIDTH     = 32,
	parameter int PRIORITY_WIDTH = 16,
	localparam int AW            = $clog2(DEPTH),
	localparam int CW            = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	spq_in_if.sink                    in_ch,
	spq_out_if.source                 out_ch,
	output spq_pkg::mem_ctrl_t        mem_ctl,
	output logic [AW-1:0]             wr_addr,
	output logic [DATA_WIDTH-1:0]     wr_data,
	output logic [PRIORITY_WIDTH-1:0] wr_prio,
	output logic [AW-1:0]             rd_addr,
	input  logic [DATA_WIDTH-1:0]     rd_data,
	input  logic [PRIORITY_WIDTH-1:0] rd_prio
);

	localparam int SW = CW + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_STEP = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                    state_q;
	logic                      op_q;
	logic [DATA_WIDTH-1:0]     data_q;
	logic [PRIORITY_WIDTH-1:0] prio_q;
	logic [CW-1:0]             idx_q;
	logic [AW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic [DATA_WIDTH-1:0]     popped_q;
	spq_pkg::err_code_t        err_q;

	logic                      out_valid_q;
	logic [DATA_WIDTH-1:0]     out_data_q;
	logic                      out_pvalid_q;
	spq_pkg::err_code_t        out_err_q;
	logic [CW-1:0]             out_count_q;

	logic                      prio_keep;
	logic                      out_free;

	// Logical slot to physical address; the ring starts at head_q.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
		logic [SW-1:0] s;
		s = SW'(head) + SW'(l);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign prio_keep = (rd_prio >= prio_q);
	assign out_free  = !out_valid_q || out_ch.ready;

	assign in_ch.ready = (state_q == S_IDLE);

	always_comb begin
		mem_ctl = '0;
		wr_addr = '0;
		wr_data = data_q;
		wr_prio = prio_q;
		rd_addr = phys(head_q, idx_q - CW'(1));
		unique case (state_q)
			S_READ: begin
				if (op_q == spq_pkg::OP_INSERT && idx_q == '0) begin
					mem_ctl.wr_en = 1'b1;
					wr_addr = phys(head_q, '0);
				end else begin
					mem_ctl.rd_en = 1'b1;
				end
			end
			S_STEP: begin
				if (op_q == spq_pkg::OP_INSERT) begin
					mem_ctl.wr_en = 1'b1;
					wr_addr = phys(head_q, idx_q);
					// A lower-priority entry moves one slot toward the tail.
					if (!prio_keep) begin
						wr_data = rd_data;
						wr_prio = rd_prio;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= spq_pkg::OP_INSERT;
			data_q       <= '0;
			prio_q       <= '0;
			idx_q        <= '0;
			head_q       <= '0;
			count_q      <= '0;
			popped_q     <= '0;
			err_q        <= spq_pkg::ERR_NONE;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_pvalid_q <= 1'b0;
			out_err_q    <= spq_pkg::ERR_NONE;
			out_count_q  <= '0;
		end else begin
			// In S_FIN the output register is reloaded below instead.
			if (out_valid_q && out_ch.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						op_q     <= in_ch.opcode;
						data_q   <= in_ch.item_data;
						prio_q   <= in_ch.item_priority;
						popped_q <= '0;
						err_q    <= spq_pkg::ERR_NONE;
						if (in_ch.opcode == spq_pkg::OP_POP) begin
							idx_q <= CW'(1);
							if (count_q == '0) begin
								err_q   <= spq_pkg::ERR_EMPTY;
								state_q <= S_FIN;
							end else begin
								state_q <= S_READ;
							end
						end else begin
							idx_q <= count_q;
							if (count_q == CW'(DEPTH)) begin
								err_q   <= spq_pkg::ERR_FULL;
								state_q <= S_FIN;
							end else begin
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					if (op_q == spq_pkg::OP_INSERT && idx_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (op_q == spq_pkg::OP_POP) begin
						popped_q <= rd_data;
						head_q   <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
						count_q  <= count_q - CW'(1);
						state_q  <= S_FIN;
					end else if (prio_keep) begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q - CW'(1);
						state_q <= S_READ;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= popped_q;
						out_pvalid_q <= (op_q == spq_pkg::OP_POP) && (err_q == spq_pkg::ERR_NONE);
						out_err_q    <= err_q;
						out_count_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.popped_data  = out_data_q;
	assign out_ch.popped_valid = out_pvalid_q;
	assign out_ch.error_code   = out_err_q;
	assign out_ch.entry_count  = out_count_q;
	assign out_ch.queue_empty  = (out_count_q == '0);

endmodule

/* verif/stable_priority_queue_core_test.sv */
// Testbench for stable_priority_queue_core: directed and random insert/pop requests,
// checked against a sorted-store predictor kept in a small scoreboard class.
// Depends on spq_pkg, spq_in_if, spq_out_if and the stable_priority_queue_core RTL.
module stable_priority_queue_core_test;

	localparam int DEPTH        = 16;
	localparam int DATA_W       = 32;
	localparam int PRIO_W       = 16;
	localparam int COUNT_W      = 5;
	localparam int RANDOM_ITEMS = 1385;
	localparam int HOLD_CYCLES  = 300;
	// Slowest insert shifts every entry; leave room for a stray result after the last one.
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

	typedef struct packed {
		logic [DATA_W-1:0]  popped_data;
		logic               popped_valid;
		spq_pkg::err_code_t error_code;
		logic [COUNT_W-1:0] entry_count;
		logic               queue_empty;
	} pq_result_t;

	class priority_order_tracker;
		logic [DATA_W-1:0] slot_data [DEPTH];
		logic [PRIO_W-1:0] slot_prio [DEPTH];
		int unsigned       fill;
		pq_result_t        pending_results [$];
		int unsigned       errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		// Applies one accepted request to the sorted store and queues its result.
		function void note_request(logic op, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] prio);
			pq_result_t  r;
			int unsigned pos;
			int unsigned i;
			r = '0;
			r.error_code = spq_pkg::ERR_NONE;
			if (op == spq_pkg::OP_INSERT) begin
				if (fill == DEPTH) begin
					r.error_code = spq_pkg::ERR_FULL;
				end else begin
					// Equal priorities stay behind the ones already stored.
					pos = 0;
					while (pos < fill && slot_prio[pos] >= prio)
						pos++;
					for (i = fill; i > pos; i--) begin
						slot_data[i] = slot_data[i-1];
						slot_prio[i] = slot_prio[i-1];
					end
					slot_data[pos] = data;
					slot_prio[pos] = prio;
					fill++;
				end
			end else begin
				if (fill == 0) begin
					r.error_code = spq_pkg::ERR_EMPTY;
				end else begin
					r.popped_data  = slot_data[0];
					r.popped_valid = 1'b1;
					for (i = 1; i < fill; i++) begin
						slot_data[i-1] = slot_data[i];
						slot_prio[i-1] = slot_prio[i];
					end
					fill--;
				end
			end
			r.entry_count = fill[COUNT_W-1:0];
			r.queue_empty = (fill == 0);
			pending_results.push_back(r);
		endfunction

		function void flag_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0h, got %0h", name, want, seen);
				errors++;
			end
		endfunction

		function void check_result(pq_result_t seen);
			pq_result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no request waiting: popped_data %0h", seen.popped_data);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			flag_field("popped_data", want.popped_data, seen.popped_data);
			flag_field("popped_valid", DATA_W'(want.popped_valid), DATA_W'(seen.popped_valid));
			flag_field("error_code", DATA_W'(want.error_code), DATA_W'(seen.error_code));
			flag_field("entry_count", DATA_W'(want.entry_count), DATA_W'(seen.entry_count));
			flag_field("queue_empty", DATA_W'(want.queue_empty), DATA_W'(seen.queue_empty));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   hold_req;

	priority_order_tracker tracker = new();

	spq_in_if #(.DATA_WIDTH(DATA_W), .PRIORITY_WIDTH(PRIO_W)) in_ch ();
	spq_out_if #(.DATA_WIDTH(DATA_W), .COUNT_WIDTH(COUNT_W)) out_ch ();

	stable_priority_queue_core #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_W),
		.PRIORITY_WIDTH(PRIO_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #5 clk = ~clk;

	task automatic send_request(logic op, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] prio);
		in_ch.valid         <= 1'b1;
		in_ch.opcode        <= op;
		in_ch.item_data     <= data;
		in_ch.item_priority <= prio;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		tracker.note_request(op, data, prio);
	endtask

	task automatic idle_sender(int unsigned cycles);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	function automatic logic [PRIO_W-1:0] pick_priority(int unsigned mode);
		logic [PRIO_W-1:0] edges [6] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE,
			16'hFFFF};
		case (mode)
			0: begin
				// A narrow range makes ties common, which exercises arrival order.
				if ($urandom_range(0, 9) == 0)
					return PRIO_W'($urandom);
				return PRIO_W'($urandom_range(0, 3));
			end
			1: return PRIO_W'($urandom);
			default: return edges[$urandom_range(0, 5)];
		endcase
	endfunction

	initial begin : stimulus
		int unsigned sent;
		int unsigned phase_idx;
		int unsigned phase_len;
		int unsigned insert_pct;
		int unsigned prio_mode;
		int unsigned burst_left;
		int unsigned k;
		bit          gaps_on;
		logic        op;
		in_ch.valid         <= 1'b0;
		in_ch.opcode        <= spq_pkg::OP_INSERT;
		in_ch.item_data     <= '0;
		in_ch.item_priority <= '0;
		arst_n              <= 1'b0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty pop, extreme values, ties at both ends of the priority range.
		send_request(spq_pkg::OP_POP, 32'h1234_5678, 16'h0);
		send_request(spq_pkg::OP_INSERT, 32'h0000_0000, 16'h0000);
		send_request(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(spq_pkg::OP_INSERT, 32'h0000_0001, 16'h0000);
		send_request(spq_pkg::OP_INSERT, 32'h0000_0002, 16'hFFFF);
		send_request(spq_pkg::OP_INSERT, 32'h0000_0003, 16'h8000);
		send_request(spq_pkg::OP_INSERT, 32'hAAAA_5555, 16'h5555);
		send_request(spq_pkg::OP_INSERT, 32'h5555_AAAA, 16'hAAAA);
		repeat (7) send_request(spq_pkg::OP_POP, 32'hDEAD_BEEF, 16'hFFFF);
		send_request(spq_pkg::OP_POP, 32'h0, 16'h0);
		wait_drained();

		sent      = 0;
		phase_idx = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(30, 80);
			case (phase_idx % 3)
				0: insert_pct = $urandom_range(75, 92);
				1: insert_pct = $urandom_range(8, 25);
				default: insert_pct = 50;
			endcase
			prio_mode = $urandom_range(0, 2);
			gaps_on   = ($urandom_range(0, 3) != 0);
			if (phase_idx == 3) begin
				// Receiver stops for a long while; requests keep coming until the input stalls.
				wait_drained();
				hold_req   = 1'b1;
				gaps_on    = 1'b0;
				insert_pct = 90;
			end else if (phase_idx % 7 == 6) begin
				wait_drained();
			end
			burst_left = $urandom_range(1, 24);
			for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				if (gaps_on && burst_left == 0) begin
					idle_sender($urandom_range(1, 12));
					burst_left = $urandom_range(1, 24);
				end
				op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP;
				send_request(op, $urandom, pick_priority(prio_mode));
				sent++;
				if (burst_left != 0)
					burst_left--;
			end
			phase_idx++;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("stable_priority_queue_core_test passed");
		end else begin
			$display("stable_priority_queue_core_test failed");
		end
		$finish;
	end

	initial begin : receiver
		int unsigned cyc;
		int unsigned hold_left;
		out_ch.ready <= 1'b0;
		cyc       = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else begin
				case ((cyc / 113) % 4)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					2: out_ch.ready <= (cyc % 6 == 0);
					default: out_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin : result_monitor
		pq_result_t seen;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				seen.popped_data  = out_ch.popped_data;
				seen.popped_valid = out_ch.popped_valid;
				seen.error_code   = spq_pkg::err_code_t'(out_ch.error_code);
				seen.entry_count  = out_ch.entry_count;
				seen.queue_empty  = out_ch.queue_empty;
				tracker.check_result(seen);
			end
		end
	end

	initial begin : watchdog
		#5000000;
		$display("stable_priority_queue_core_test failed");
		$finish;
	end

endmodule
